/* rtl/core/utc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_pkg: shared types and constants of the Unicode transcoder
// Format codes, register indexes, UTF-8/UTF-16 constants and the result
// burst handed from the encoder to the output buffer.
// ----------------------------------------------------------------------------
package utc_pkg;

	localparam int unsigned FMT_W   = 3;
	localparam int unsigned MAX_OUT = 8;
	localparam int unsigned CNT_W   = $clog2(MAX_OUT + 1);
	localparam int unsigned IDX_W   = $clog2(MAX_OUT);

	// register indexes
	localparam logic REG_SOURCE_FORMAT = 1'b0;
	localparam logic REG_TARGET_FORMAT = 1'b1;

	// format codes; codes not listed fall back to UTF-8
	localparam logic [FMT_W-1:0] FMT_UTF8     = 3'd0;
	localparam logic [FMT_W-1:0] FMT_UTF8_BOM = 3'd1;
	localparam logic [FMT_W-1:0] FMT_UTF16LE  = 3'd2;
	localparam logic [FMT_W-1:0] FMT_UTF16BE  = 3'd3;
	localparam logic [FMT_W-1:0] FMT_UTF32LE  = 3'd4;
	localparam logic [FMT_W-1:0] FMT_UTF32BE  = 3'd5;

	localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
	localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
	localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
	localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;
	localparam logic [20:0] SUPP_BASE    = 21'h10000;
	localparam logic [31:0] CP_LIMIT     = 32'h110000;

	localparam logic [7:0] UTF8_LEAD4 = 8'd240;
	localparam logic [7:0] UTF8_LEAD3 = 8'd224;
	localparam logic [7:0] UTF8_LEAD2 = 8'd192;
	localparam logic [7:0] UTF8_CONT  = 8'd128;

	typedef struct packed {
		logic        bom;      // target BOM goes first
		logic        cp_valid; // a code point completed
		logic [31:0] cp;
	} utc_decoded_t;

	typedef struct packed {
		logic [8*MAX_OUT-1:0] bytes; // first byte in the lowest bits
		logic [CNT_W-1:0]     count;
	} utc_burst_t;

endpackage

/* rtl/core/utc_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_decode: source decoder
// Holds the partial code point state and assembles code points from the
// source byte stream; joins UTF-16 surrogate pairs.
// ----------------------------------------------------------------------------
module utc_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [7:0]                    in_byte,
	input  logic                          stream_start,
	input  logic [utc_pkg::FMT_W-1:0]     source_format,
	output utc_pkg::utc_decoded_t         dec
);

	logic [31:0] acc_q, acc_d, acc_e;
	logic [1:0]  seen_q, seen_d, seen_e;
	logic [2:0]  need_q, need_d, need_e;
	logic [9:0]  hh_q, hh_d, hh_e;
	logic        hv_q, hv_d, hv_e;
	logic        bom_q;

	logic [15:0] unit;
	logic [31:0] acc32;
	logic [31:0] cont;
	logic [31:0] cp;
	logic        cp_valid;

	always_comb begin
		// stream_start wipes partial state before the byte is handled
		acc_e  = stream_start ? '0 : acc_q;
		seen_e = stream_start ? '0 : seen_q;
		need_e = stream_start ? '0 : need_q;
		hh_e   = stream_start ? '0 : hh_q;
		hv_e   = stream_start ? 1'b0 : hv_q;

		acc_d    = acc_e;
		seen_d   = seen_e;
		need_d   = need_e;
		hh_d     = hh_e;
		hv_d     = hv_e;
		cp       = '0;
		cp_valid = 1'b0;

		unit  = (source_format == utc_pkg::FMT_UTF16LE) ? {in_byte, acc_e[7:0]}
			: {acc_e[7:0], in_byte};
		acc32 = (source_format == utc_pkg::FMT_UTF32LE)
			? (acc_e | ({24'd0, in_byte} << {seen_e, 3'b000}))
			: {acc_e[23:0], in_byte};
		cont  = {acc_e[25:0], in_byte[5:0]};

		case (source_format)
			utc_pkg::FMT_UTF16LE, utc_pkg::FMT_UTF16BE: begin
				if (seen_e == 2'd0) begin
					acc_d  = {24'd0, in_byte};
					seen_d = 2'd1;
				end else begin
					seen_d = 2'd0;
					acc_d  = '0;
					if (hv_e) begin
						hv_d     = 1'b0;
						hh_d     = '0;
						cp       = {11'd0, {1'b0, hh_e, unit[9:0]} + utc_pkg::SUPP_BASE};
						cp_valid = 1'b1;
					end else if (unit >= utc_pkg::HIGH_SURR_LO
							&& unit <= utc_pkg::HIGH_SURR_HI) begin
						hh_d = unit[9:0];
						hv_d = 1'b1;
					end else begin
						cp       = {16'd0, unit};
						cp_valid = 1'b1;
					end
				end
			end
			utc_pkg::FMT_UTF32LE, utc_pkg::FMT_UTF32BE: begin
				if (seen_e != 2'd3) begin
					acc_d  = acc32;
					seen_d = seen_e + 2'd1;
				end else begin
					cp       = acc32;
					cp_valid = 1'b1;
					acc_d    = '0;
					seen_d   = 2'd0;
				end
			end
			default: begin
				if (need_e != 3'd0) begin
					if ({1'b0, seen_e} + 3'd1 >= need_e) begin
						cp       = cont;
						cp_valid = 1'b1;
						acc_d    = '0;
						seen_d   = '0;
						need_d   = '0;
						hh_d     = '0;
						hv_d     = 1'b0;
					end else begin
						acc_d  = cont;
						seen_d = seen_e + 2'd1;
					end
				end else if (!in_byte[7]) begin
					cp       = {24'd0, in_byte};
					cp_valid = 1'b1;
				end else if (in_byte[7:5] == 3'b110) begin
					acc_d  = {27'd0, in_byte[4:0]};
					need_d = 3'd1;
					seen_d = 2'd0;
				end else if (in_byte[7:4] == 4'b1110) begin
					acc_d  = {28'd0, in_byte[3:0]};
					need_d = 3'd2;
					seen_d = 2'd0;
				end else if (in_byte[7:3] == 5'b11110) begin
					acc_d  = {29'd0, in_byte[2:0]};
					need_d = 3'd3;
					seen_d = 2'd0;
				end else begin
					// invalid lead byte gives U+0000
					cp       = '0;
					cp_valid = 1'b1;
				end
			end
		endcase
	end

	assign dec.bom      = bom_q | stream_start;
	assign dec.cp_valid = cp_valid;
	assign dec.cp       = cp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			seen_q <= '0;
			need_q <= '0;
			hh_q   <= '0;
			hv_q   <= 1'b0;
			bom_q  <= 1'b1;
		end else if (take) begin
			acc_q  <= acc_d;
			seen_q <= seen_d;
			need_q <= need_d;
			hh_q   <= hh_d;
			hv_q   <= hv_d;
			bom_q  <= 1'b0;
		end
	end

endmodule

/* rtl/core/utc_encode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_encode: target encoder
// Builds the byte burst for one input transaction: optional BOM followed
// by the code point in the target encoding.
// ----------------------------------------------------------------------------
module utc_encode (
	input  utc_pkg::utc_decoded_t         dec,
	input  logic [utc_pkg::FMT_W-1:0]     target_format,
	output utc_pkg::utc_burst_t           burst
);

	logic [31:0] bom_bytes, enc_bytes;
	logic [2:0]  bom_len, enc_len;
	logic [31:0] cp;
	logic [19:0] v;
	logic [15:0] u1, u2;

	assign cp = dec.cp;
	assign v  = 20'(cp[20:0] - utc_pkg::SUPP_BASE);
	assign u1 = {utc_pkg::HIGH_SURR_TAG, v[19:10]};
	assign u2 = {utc_pkg::LOW_SURR_TAG, v[9:0]};

	// BOM, first byte in the lowest bits
	always_comb begin
		bom_bytes = '0;
		bom_len   = '0;
		if (dec.bom) begin
			case (target_format)
				utc_pkg::FMT_UTF8_BOM: begin
					bom_bytes = {8'h00, 8'hBF, 8'hBB, 8'hEF};
					bom_len   = 3'd3;
				end
				utc_pkg::FMT_UTF16LE: begin
					bom_bytes = {16'h0000, 8'hFE, 8'hFF};
					bom_len   = 3'd2;
				end
				utc_pkg::FMT_UTF16BE: begin
					bom_bytes = {16'h0000, 8'hFF, 8'hFE};
					bom_len   = 3'd2;
				end
				utc_pkg::FMT_UTF32LE: begin
					bom_bytes = {8'h00, 8'h00, 8'hFE, 8'hFF};
					bom_len   = 3'd4;
				end
				utc_pkg::FMT_UTF32BE: begin
					bom_bytes = {8'hFF, 8'hFE, 8'h00, 8'h00};
					bom_len   = 3'd4;
				end
				default: begin
					bom_bytes = '0;
					bom_len   = '0;
				end
			endcase
		end
	end

	always_comb begin
		enc_bytes = '0;
		enc_len   = '0;
		if (dec.cp_valid) begin
			case (target_format)
				utc_pkg::FMT_UTF16LE, utc_pkg::FMT_UTF16BE: begin
					if (cp[31:16] == 16'd0) begin
						enc_len   = 3'd2;
						enc_bytes = (target_format == utc_pkg::FMT_UTF16LE)
							? {16'd0, cp[15:8], cp[7:0]} : {16'd0, cp[7:0], cp[15:8]};
					end else if (cp < utc_pkg::CP_LIMIT) begin
						enc_len   = 3'd4;
						enc_bytes = (target_format == utc_pkg::FMT_UTF16LE)
							? {u2[15:8], u2[7:0], u1[15:8], u1[7:0]}
							: {u2[7:0], u2[15:8], u1[7:0], u1[15:8]};
					end
				end
				utc_pkg::FMT_UTF32LE: begin
					enc_len   = 3'd4;
					enc_bytes = cp;
				end
				utc_pkg::FMT_UTF32BE: begin
					enc_len   = 3'd4;
					enc_bytes = {cp[7:0], cp[15:8], cp[23:16], cp[31:24]};
				end
				default: begin
					if (cp < 32'h80) begin
						enc_len   = 3'd1;
						enc_bytes = {24'd0, cp[7:0]};
					end else if (cp < 32'h800) begin
						enc_len   = 3'd2;
						enc_bytes = {16'd0, utc_pkg::UTF8_CONT | {2'b00, cp[5:0]},
							utc_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]}};
					end else if (cp < 32'h10000) begin
						enc_len   = 3'd3;
						enc_bytes = {8'd0, utc_pkg::UTF8_CONT | {2'b00, cp[5:0]},
							utc_pkg::UTF8_CONT | {2'b00, cp[11:6]},
							utc_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]}};
					end else if (cp < utc_pkg::CP_LIMIT) begin
						// top bits stay at most 4 here, so the OR cannot carry
						enc_len   = 3'd4;
						enc_bytes = {utc_pkg::UTF8_CONT | {2'b00, cp[5:0]},
							utc_pkg::UTF8_CONT | {2'b00, cp[11:6]},
							utc_pkg::UTF8_CONT | {2'b00, cp[17:12]},
							utc_pkg::UTF8_LEAD4 | {5'b00000, cp[20:18]}};
					end
				end
			endcase
		end
	end

	assign burst.bytes = ({32'd0, enc_bytes} << {bom_len, 3'b000}) | {32'd0, bom_bytes};
	assign burst.count = utc_pkg::CNT_W'({1'b0, bom_len} + {1'b0, enc_len});

endmodule

/* rtl/core/utc_outbuf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utc_outbuf: result buffer and byte serialiser
// Holds one burst and hands it out one byte per transaction; frees itself
// in the cycle its last byte is taken so the next burst loads straight in.
// ----------------------------------------------------------------------------
module utc_outbuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  utc_pkg::utc_burst_t burst,
	output logic                free,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tlast
);

	logic [8*utc_pkg::MAX_OUT-1:0] bytes_q;
	logic [utc_pkg::CNT_W-1:0]     rem_q;
	logic [utc_pkg::IDX_W-1:0]     idx_q;
	logic                          take;

	assign m_tvalid = (rem_q != '0);
	assign m_tlast  = (rem_q == utc_pkg::CNT_W'(1));
	assign m_tdata  = bytes_q[{idx_q, 3'b000} +: 8];
	assign take     = m_tvalid & m_tready;
	assign free     = !m_tvalid || (m_tlast && m_tready);

	always_ff @(posedge clk) begin
		if (load)
			bytes_q <= burst.bytes;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			rem_q <= burst.count;
			idx_q <= '0;
		end else if (take) begin
			rem_q <= rem_q - utc_pkg::CNT_W'(1);
			idx_q <= idx_q + utc_pkg::IDX_W'(1);
		end
	end

endmodule

/* rtl/core/unicode_transcoder.sv */
`timescale 1ns / 1ps
// The first result byte of an input byte is valid in the cycle after the byte is accepted.
// An input byte that yields N result bytes (0..8, BOM included) holds the output buffer
// until its last byte is taken; the next input is taken in the cycle the last byte leaves,
// so with the one-byte-wide output port a new input byte waits until the last one is out.
// Reset (arst_n low, asynchronous): both formats UTF-8, partial state cleared, BOM armed.
// ----------------------------------------------------------------------------
// unicode_transcoder: UTF-8 / UTF-16 / UTF-32 byte stream transcoder
// Decodes the source byte stream into code points and re-encodes each one
// in the target format, one output byte per transaction.
// ----------------------------------------------------------------------------
module unicode_transcoder (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_we,
	input  logic                      cfg_idx,
	input  logic [utc_pkg::FMT_W-1:0] cfg_wdata,
	// source bytes
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,  // [7:0] in_byte
	input  logic                      s_tuser,  // [0] stream_start
	// target bytes
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata,  // [7:0] out_byte
	output logic                      m_tlast   // last_of_run
);

	logic [utc_pkg::FMT_W-1:0] source_format_q, target_format_q;
	logic                      take;
	utc_pkg::utc_decoded_t     dec;
	utc_pkg::utc_burst_t       burst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= utc_pkg::FMT_UTF8;
			target_format_q <= utc_pkg::FMT_UTF8;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				utc_pkg::REG_SOURCE_FORMAT: source_format_q <= cfg_wdata;
				utc_pkg::REG_TARGET_FORMAT: target_format_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign take = s_tvalid & s_tready;

	utc_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.in_byte       (s_tdata),
		.stream_start  (s_tuser),
		.source_format (source_format_q),
		.dec           (dec)
	);

	utc_encode u_encode (
		.dec           (dec),
		.target_format (target_format_q),
		.burst         (burst)
	);

	utc_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.burst    (burst),
		.free     (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the Unicode transcoder
// Feeds source bytes in directed and random format pairs, with the byte-order mark,
// surrogate pairs, invalid lead bytes and out-of-range code points, and
// compares every output byte against a cycle-free model of the transcoder.
// ----------------------------------------------------------------------------

class transcode_scoreboard;
	logic [utc_pkg::FMT_W-1:0] src_fmt;
	logic [utc_pkg::FMT_W-1:0] dst_fmt;
	logic [31:0]      accum;
	logic [1:0]       seen;
	logic [2:0]       needed;
	logic [9:0]       high_bits;
	bit               have_high;
	bit               bom_armed;
	logic [7:0]       run_bytes[$];
	logic [7:0]       bytes_due[$];
	bit               lasts_due[$];
	int               mismatches;

	function new();
		src_fmt = utc_pkg::FMT_UTF8;
		dst_fmt = utc_pkg::FMT_UTF8;
		clear_partial();
		bom_armed = 1'b1;
		mismatches = 0;
	endfunction

	function void clear_partial();
		accum = '0;
		seen = '0;
		needed = '0;
		high_bits = '0;
		have_high = 1'b0;
	endfunction

	function void write_reg(logic idx, logic [utc_pkg::FMT_W-1:0] val);
		if (idx == utc_pkg::REG_SOURCE_FORMAT)
			src_fmt = val;
		else
			dst_fmt = val;
	endfunction

	function void put_bom();
		case (dst_fmt)
			utc_pkg::FMT_UTF8_BOM: begin
				run_bytes.push_back(8'hEF);
				run_bytes.push_back(8'hBB);
				run_bytes.push_back(8'hBF);
			end
			utc_pkg::FMT_UTF16LE: begin
				run_bytes.push_back(8'hFF);
				run_bytes.push_back(8'hFE);
			end
			utc_pkg::FMT_UTF16BE: begin
				run_bytes.push_back(8'hFE);
				run_bytes.push_back(8'hFF);
			end
			utc_pkg::FMT_UTF32LE: begin
				run_bytes.push_back(8'hFF);
				run_bytes.push_back(8'hFE);
				run_bytes.push_back(8'h00);
				run_bytes.push_back(8'h00);
			end
			utc_pkg::FMT_UTF32BE: begin
				run_bytes.push_back(8'h00);
				run_bytes.push_back(8'h00);
				run_bytes.push_back(8'hFE);
				run_bytes.push_back(8'hFF);
			end
			default: ;
		endcase
	endfunction

	function void put_code_point(logic [31:0] cp);
		logic [31:0] off;
		logic [15:0] hi_u;
		logic [15:0] lo_u;
		case (dst_fmt)
			utc_pkg::FMT_UTF16LE, utc_pkg::FMT_UTF16BE: begin
				if (cp < 32'h10000) begin
					hi_u = cp[15:0];
					if (dst_fmt == utc_pkg::FMT_UTF16LE) begin
						run_bytes.push_back(hi_u[7:0]);
						run_bytes.push_back(hi_u[15:8]);
					end else begin
						run_bytes.push_back(hi_u[15:8]);
						run_bytes.push_back(hi_u[7:0]);
					end
				end else if (cp < utc_pkg::CP_LIMIT) begin
					off = cp - utc_pkg::SUPP_BASE;
					hi_u = {utc_pkg::HIGH_SURR_TAG, off[19:10]};
					lo_u = {utc_pkg::LOW_SURR_TAG, off[9:0]};
					if (dst_fmt == utc_pkg::FMT_UTF16LE) begin
						run_bytes.push_back(hi_u[7:0]);
						run_bytes.push_back(hi_u[15:8]);
						run_bytes.push_back(lo_u[7:0]);
						run_bytes.push_back(lo_u[15:8]);
					end else begin
						run_bytes.push_back(hi_u[15:8]);
						run_bytes.push_back(hi_u[7:0]);
						run_bytes.push_back(lo_u[15:8]);
						run_bytes.push_back(lo_u[7:0]);
					end
				end
			end
			utc_pkg::FMT_UTF32LE: begin
				for (int i = 0; i < 4; i++)
					run_bytes.push_back(cp[8*i +: 8]);
			end
			utc_pkg::FMT_UTF32BE: begin
				for (int i = 3; i >= 0; i--)
					run_bytes.push_back(cp[8*i +: 8]);
			end
			default: begin
				if (cp < 32'h80) begin
					run_bytes.push_back(cp[7:0]);
				end else if (cp < 32'h800) begin
					run_bytes.push_back(utc_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]});
					run_bytes.push_back(utc_pkg::UTF8_CONT | {2'b00, cp[5:0]});
				end else if (cp < 32'h10000) begin
					run_bytes.push_back(utc_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]});
					run_bytes.push_back(utc_pkg::UTF8_CONT | {2'b00, cp[11:6]});
					run_bytes.push_back(utc_pkg::UTF8_CONT | {2'b00, cp[5:0]});
				end else if (cp < utc_pkg::CP_LIMIT) begin
					run_bytes.push_back(utc_pkg::UTF8_LEAD4 | {5'b00000, cp[20:18]});
					run_bytes.push_back(utc_pkg::UTF8_CONT | {2'b00, cp[17:12]});
					run_bytes.push_back(utc_pkg::UTF8_CONT | {2'b00, cp[11:6]});
					run_bytes.push_back(utc_pkg::UTF8_CONT | {2'b00, cp[5:0]});
				end
			end
		endcase
	endfunction

	// returns 1 when a code point is complete
	function bit decode_byte(logic [7:0] b, output logic [31:0] cp);
		logic [15:0] unit;
		cp = '0;
		case (src_fmt)
			utc_pkg::FMT_UTF16LE, utc_pkg::FMT_UTF16BE: begin
				if (seen == 0) begin
					accum = {24'b0, b};
					seen = 2'd1;
					return 1'b0;
				end
				unit = (src_fmt == utc_pkg::FMT_UTF16LE) ? {b, accum[7:0]}
					: {accum[7:0], b};
				seen = '0;
				accum = '0;
				if (have_high) begin
					// whatever follows a high half is taken as the low half
					have_high = 1'b0;
					cp = utc_pkg::SUPP_BASE + {high_bits, unit[9:0]};
					high_bits = '0;
					return 1'b1;
				end
				if (unit >= utc_pkg::HIGH_SURR_LO && unit <= utc_pkg::HIGH_SURR_HI) begin
					high_bits = unit[9:0];
					have_high = 1'b1;
					return 1'b0;
				end
				cp = {16'b0, unit};
				return 1'b1;
			end
			utc_pkg::FMT_UTF32LE, utc_pkg::FMT_UTF32BE: begin
				if (src_fmt == utc_pkg::FMT_UTF32LE)
					accum = accum | ({24'b0, b} << (8 * seen));
				else
					accum = {accum[23:0], b};
				if (seen < 2'd3) begin
					seen = seen + 2'd1;
					return 1'b0;
				end
				cp = accum;
				accum = '0;
				seen = '0;
				return 1'b1;
			end
			default: begin
				if (needed != 0) begin
					// continuation top bits are not checked
					accum = {accum[25:0], b[5:0]};
					if (int'(seen) + 1 >= int'(needed)) begin
						cp = accum;
						clear_partial();
						return 1'b1;
					end
					seen = seen + 2'd1;
					return 1'b0;
				end
				if (!b[7]) begin
					cp = {24'b0, b};
					return 1'b1;
				end
				if (b[7:5] == 3'b110) begin
					accum = {27'b0, b[4:0]};
					needed = 3'd1;
					seen = '0;
					return 1'b0;
				end
				if (b[7:4] == 4'b1110) begin
					accum = {28'b0, b[3:0]};
					needed = 3'd2;
					seen = '0;
					return 1'b0;
				end
				if (b[7:3] == 5'b11110) begin
					accum = {29'b0, b[2:0]};
					needed = 3'd3;
					seen = '0;
					return 1'b0;
				end
				// bad lead byte gives U+0000
				return 1'b1;
			end
		endcase
	endfunction

	function void take_source_byte(logic [7:0] b, logic start);
		logic [31:0] cp;
		run_bytes.delete();
		if (start) begin
			clear_partial();
			bom_armed = 1'b1;
		end
		if (bom_armed) begin
			put_bom();
			bom_armed = 1'b0;
		end
		if (decode_byte(b, cp))
			put_code_point(cp);
		foreach (run_bytes[i]) begin
			bytes_due.push_back(run_bytes[i]);
			lasts_due.push_back(i == run_bytes.size() - 1);
		end
	endfunction

	function void check_out_byte(logic [7:0] b, logic last);
		logic [7:0] want_b;
		bit         want_l;
		if (bytes_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected output byte %02h last %0b", b, last);
			return;
		end
		want_b = bytes_due.pop_front();
		want_l = lasts_due.pop_front();
		if (b !== want_b || last !== want_l) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected byte %02h last %0b, got byte %02h last %0b",
					want_b, want_l, b, last);
		end
	endfunction

	function int pending();
		return bytes_due.size();
	endfunction
endclass

module tb;
	typedef logic [7:0] byte_list_t[$];

	// codes outside the listed formats, decoded and encoded as plain UTF-8
	localparam logic [utc_pkg::FMT_W-1:0] FMT_SPARE_A = 3'd6;
	localparam logic [utc_pkg::FMT_W-1:0] FMT_SPARE_B = 3'd7;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic             cfg_idx = utc_pkg::REG_SOURCE_FORMAT;
	logic [utc_pkg::FMT_W-1:0] cfg_wdata = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = '0;
	logic             s_tuser = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;
	logic             m_tlast;

	bit               calm = 1'b0;
	int               sent = 0;
	transcode_scoreboard sb = new();

	unicode_transcoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= 38);
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.take_source_byte(s_tdata, s_tuser);
		if (arst_n && m_tvalid && m_tready)
			sb.check_out_byte(m_tdata, m_tlast);
	end

	task automatic push_byte(input logic [7:0] b, input logic start);
		while (!calm && $urandom_range(99) < 38) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= start;
		do
			@(posedge clk);
		while (!s_tready);
		sent++;
	endtask

	// drain all expected bytes, then idle on to also cover a byte that gives none
	task automatic settle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [utc_pkg::FMT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [utc_pkg::FMT_W-1:0] pick_fmt();
		if ($urandom_range(99) < 12)
			return $urandom_range(1) ? FMT_SPARE_A : FMT_SPARE_B;
		return utc_pkg::FMT_W'($urandom_range(5));
	endfunction

	function automatic logic [31:0] pick_cp(logic [utc_pkg::FMT_W-1:0] fmt);
		case ($urandom_range(9))
			0: return 32'h0;
			1: return $urandom_range(32'h7F);
			2: return $urandom_range(32'h7FF, 32'h80);
			3: return $urandom_range(32'hFFFF, 32'h800);
			4: return $urandom_range(32'hDFFF, 32'hD800);
			5: return 32'h10FFFF;
			6: return 32'hFFFF;
			7: begin
				if (fmt == utc_pkg::FMT_UTF32LE || fmt == utc_pkg::FMT_UTF32BE)
					return $urandom();
				if (fmt == utc_pkg::FMT_UTF16LE || fmt == utc_pkg::FMT_UTF16BE)
					return $urandom_range(32'h10FFFF, 32'h10000);
				return $urandom_range(32'h1FFFFF, 32'h110000);
			end
			default: return $urandom_range(32'h10FFFF, 32'h10000);
		endcase
	endfunction

	// source-side encoding of one code point, used to build well-formed text
	function automatic byte_list_t source_bytes(logic [utc_pkg::FMT_W-1:0] fmt,
			logic [31:0] cp);
		byte_list_t  q;
		logic [31:0] off;
		logic [15:0] units[$];
		case (fmt)
			utc_pkg::FMT_UTF16LE, utc_pkg::FMT_UTF16BE: begin
				if (cp < 32'h10000) begin
					units.push_back(cp[15:0]);
				end else begin
					off = cp - utc_pkg::SUPP_BASE;
					units.push_back({utc_pkg::HIGH_SURR_TAG, off[19:10]});
					units.push_back({utc_pkg::LOW_SURR_TAG, off[9:0]});
				end
				foreach (units[i]) begin
					if (fmt == utc_pkg::FMT_UTF16LE) begin
						q.push_back(units[i][7:0]);
						q.push_back(units[i][15:8]);
					end else begin
						q.push_back(units[i][15:8]);
						q.push_back(units[i][7:0]);
					end
				end
			end
			utc_pkg::FMT_UTF32LE: begin
				for (int i = 0; i < 4; i++)
					q.push_back(cp[8*i +: 8]);
			end
			utc_pkg::FMT_UTF32BE: begin
				for (int i = 3; i >= 0; i--)
					q.push_back(cp[8*i +: 8]);
			end
			default: begin
				if (cp < 32'h80) begin
					q.push_back(cp[7:0]);
				end else if (cp < 32'h800) begin
					q.push_back(utc_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]});
					q.push_back(utc_pkg::UTF8_CONT | {2'b00, cp[5:0]});
				end else if (cp < 32'h10000) begin
					q.push_back(utc_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]});
					q.push_back(utc_pkg::UTF8_CONT | {2'b00, cp[11:6]});
					q.push_back(utc_pkg::UTF8_CONT | {2'b00, cp[5:0]});
				end else begin
					q.push_back(utc_pkg::UTF8_LEAD4 | {5'b00000, cp[20:18]});
					q.push_back(utc_pkg::UTF8_CONT | {2'b00, cp[17:12]});
					q.push_back(utc_pkg::UTF8_CONT | {2'b00, cp[11:6]});
					q.push_back(utc_pkg::UTF8_CONT | {2'b00, cp[5:0]});
				end
			end
		endcase
		return q;
	endfunction

	initial begin
		logic [utc_pkg::FMT_W-1:0] src;
		byte_list_t       q;
		bit               fresh;
		bit               st;
		int               n_cp;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// UTF-8 to UTF-8 with BOM: extremes, 4-byte maximum, bad lead bytes
		write_reg(utc_pkg::REG_TARGET_FORMAT, utc_pkg::FMT_UTF8_BOM);
		write_reg(utc_pkg::REG_SOURCE_FORMAT, utc_pkg::FMT_UTF8);
		push_byte(8'h00, 1'b1);
		push_byte(8'hC3, 1'b0);
		push_byte(8'hA9, 1'b0);
		push_byte(8'hF4, 1'b0);
		push_byte(8'h8F, 1'b0);
		push_byte(8'hBF, 1'b0);
		push_byte(8'hBF, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hF8, 1'b0);

		// UTF-16LE to UTF-16BE: pair, lone low half, unpaired high half
		settle();
		write_reg(utc_pkg::REG_SOURCE_FORMAT, utc_pkg::FMT_UTF16LE);
		write_reg(utc_pkg::REG_TARGET_FORMAT, utc_pkg::FMT_UTF16BE);
		push_byte(8'h3D, 1'b1);
		push_byte(8'hD8, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hDE, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hDC, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hD8, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(8'h00, 1'b0);

		// all-ones code point: no output at all for a UTF-16 target
		settle();
		write_reg(utc_pkg::REG_SOURCE_FORMAT, utc_pkg::FMT_UTF32BE);
		write_reg(utc_pkg::REG_TARGET_FORMAT, utc_pkg::FMT_UTF16LE);
		repeat (4) push_byte(8'hFF, 1'b0);

		// format switched with a character half done
		settle();
		write_reg(utc_pkg::REG_SOURCE_FORMAT, utc_pkg::FMT_UTF8);
		write_reg(utc_pkg::REG_TARGET_FORMAT, utc_pkg::FMT_UTF32BE);
		push_byte(8'hE2, 1'b0);
		settle();
		write_reg(utc_pkg::REG_SOURCE_FORMAT, utc_pkg::FMT_UTF16BE);
		push_byte(8'h41, 1'b0);
		push_byte(8'h42, 1'b0);
		settle();
		write_reg(utc_pkg::REG_SOURCE_FORMAT, FMT_SPARE_B);
		write_reg(utc_pkg::REG_TARGET_FORMAT, FMT_SPARE_A);
		push_byte(8'h80, 1'b0);
		push_byte(8'h81, 1'b0);

		// random phases: mostly well-formed text, some noise
		while (sent < 200) begin
			settle();
			calm = (sent >= 110 && sent < 160);
			src = pick_fmt();
			write_reg(utc_pkg::REG_SOURCE_FORMAT, src);
			write_reg(utc_pkg::REG_TARGET_FORMAT, pick_fmt());
			fresh = ($urandom_range(99) < 70);
			n_cp = $urandom_range(20, 4);
			for (int k = 0; k < n_cp; k++) begin
				st = fresh || ($urandom_range(99) < 4);
				fresh = 1'b0;
				if ($urandom_range(99) < 12) begin
					push_byte(8'($urandom_range(255)), st);
				end else begin
					q = source_bytes(src, pick_cp(src));
					foreach (q[i])
						push_byte(q[i], st && i == 0);
				end
			end
		end

		calm = 1'b0;
		settle();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
